// File: design/waqa_pkg.sv
package waqa_pkg;

   localparam int NUM_QUEUES     = 3;
   localparam int TIME_BITS_DEF  = 32;
   localparam int WEIGHT_BITS    = 8;
   localparam int LEN_BITS       = 16;
   localparam int QIDX_BITS      = 2;
   localparam int STAMP_BITS     = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = WEIGHT_BITS;

   localparam logic [WEIGHT_BITS-1:0] LOW_WEIGHT_RST  = 8'd1;
   localparam logic [WEIGHT_BITS-1:0] MID_WEIGHT_RST  = 8'd5;
   localparam logic [WEIGHT_BITS-1:0] HIGH_WEIGHT_RST = 8'd9;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_WEIGHT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MID_WEIGHT = 2'd1;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_SET_LENGTH = 2'd1,
      OP_SET_LAST   = 2'd2,
      OP_SET_WEIGHT = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]             operation;
      logic [QIDX_BITS-1:0]   queue_index;
      logic [LEN_BITS-1:0]    queue_length;
      logic [STAMP_BITS-1:0]  last_service_time;
      logic [WEIGHT_BITS-1:0] weight_update;
      logic [STAMP_BITS-1:0]  current_time;
   } req_type;

   typedef struct packed {
      logic                   grant_valid;
      logic [QIDX_BITS-1:0]   grant_queue;
      logic [WEIGHT_BITS-1:0] reported_weight;
   } rsp_type;

endpackage

// File: design/waqa_score.sv
module waqa_score
   import waqa_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic [WEIGHT_BITS-1:0]           weight,
   input  logic [LEN_BITS-1:0]              length,
   input  logic [TIME_BITS-1:0]             last_time,
   input  logic [TIME_BITS-1:0]             now,
   output logic [TIME_BITS+WEIGHT_BITS-1:0] score
);

   localparam int SCORE_BITS = TIME_BITS + WEIGHT_BITS;

   logic                  eligible;
   logic [TIME_BITS-1:0]  age;
   logic [SCORE_BITS-1:0] product;

   // an empty queue or a stamp not in the past scores zero and never wins
   assign eligible = (length != '0) && (now > last_time);
   assign age      = now - last_time;
   assign product  = SCORE_BITS'(weight) * SCORE_BITS'(age);
   assign score    = eligible ? product : '0;

endmodule

// File: design/waqa_pick.sv
module waqa_pick
   import waqa_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic [NUM_QUEUES-1:0][TIME_BITS+WEIGHT_BITS-1:0] scores,
   output logic [QIDX_BITS-1:0]                             grant
);

   localparam int SCORE_BITS = TIME_BITS + WEIGHT_BITS;

   logic [SCORE_BITS-1:0] best;

   // walk from the top queue down; strict compare keeps ties on the higher index
   always_comb begin
      best  = '0;
      grant = '0;
      for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
         if (scores[q] > best) begin
            best  = scores[q];
            grant = QIDX_BITS'(q);
         end
      end
   end

endmodule

// File: design/weighted_age_queue_arbiter_unit.sv
// Weighted age arbiter over three queues (0 low, 1 mid, 2 high). Each request
// beat either sets a queue length, sets a queue last-service stamp, sets the
// high-queue weight, or ticks: on a tick every non-empty queue whose stamp lies
// strictly before current_time scores weight * (current_time - stamp), and the
// largest positive score is granted, ties to the higher queue, queue 0 when no
// queue scores. Every request beat yields exactly one response beat that also
// reports the high weight as it stands after the beat. A queue index of three
// leaves the tables untouched. The block takes one beat per cycle unless the
// response side stalls; a beat passes the input register, then the response
// register, with one combinational pass of three weight-by-age multipliers
// and a three-way compare between them. Low and mid weights are written on the
// csr port by the user only while the block is idle, not enforced by the block;
// indexes past the mid weight are dropped. Times are cut or zero-extended to TIME_BITS.
module weighted_age_queue_arbiter_unit
   import waqa_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SCORE_BITS = TIME_BITS + WEIGHT_BITS;

   // input stage
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff, req_data_in;
   // response stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   // configuration and queue state
   logic [WEIGHT_BITS-1:0] low_weight_ff, low_weight_in;
   logic [WEIGHT_BITS-1:0] mid_weight_ff, mid_weight_in;
   logic [WEIGHT_BITS-1:0] high_weight_ff, high_weight_in;
   logic [NUM_QUEUES-1:0][LEN_BITS-1:0]  length_ff, length_in;
   logic [NUM_QUEUES-1:0][TIME_BITS-1:0] last_time_ff, last_time_in;

   logic                                  advance;
   logic                                  fire;
   logic                                  req_take;
   logic [TIME_BITS-1:0]                  now;
   logic [TIME_BITS-1:0]                  new_stamp;
   logic [NUM_QUEUES-1:0][WEIGHT_BITS-1:0] weight_vec;
   logic [NUM_QUEUES-1:0][SCORE_BITS-1:0]  scores;
   logic [QIDX_BITS-1:0]                  grant;

   // the response register frees up when empty or when its beat leaves
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign now       = TIME_BITS'(req_data_ff.current_time);
   assign new_stamp = TIME_BITS'(req_data_ff.last_service_time);

   assign weight_vec[0] = low_weight_ff;
   assign weight_vec[1] = mid_weight_ff;
   assign weight_vec[2] = high_weight_ff;

   // one scoring lane per queue
   for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_lane
      waqa_score #(
         .TIME_BITS(TIME_BITS)
      ) u_score (
         .weight   (weight_vec[g]),
         .length   (length_ff[g]),
         .last_time(last_time_ff[g]),
         .now      (now),
         .score    (scores[g])
      );
   end

   waqa_pick #(
      .TIME_BITS(TIME_BITS)
   ) u_pick (
      .scores(scores),
      .grant (grant)
   );

   // input register: load on every accepted beat, hold while stalled
   always_comb begin
      req_valid_in = req_stall ? req_valid_ff : req_valid;
      req_data_in  = req_take ? req_data : req_data_ff;
   end

   // csr writes
   always_comb begin
      low_weight_in = low_weight_ff;
      mid_weight_in = mid_weight_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LOW_WEIGHT: low_weight_in = csr_wdata;
            CSR_MID_WEIGHT: mid_weight_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // apply the beat in the input register and build its response
   always_comb begin
      high_weight_in = high_weight_ff;
      length_in      = length_ff;
      last_time_in   = last_time_ff;
      rsp_valid_in   = advance ? req_valid_ff : rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      if (fire) begin
         rsp_data_in.grant_valid = 1'b0;
         rsp_data_in.grant_queue = '0;
         unique case (op_type'(req_data_ff.operation))
            OP_TICK: begin
               rsp_data_in.grant_valid = 1'b1;
               rsp_data_in.grant_queue = grant;
            end
            OP_SET_LENGTH: begin
               for (int q = 0; q < NUM_QUEUES; q++) begin
                  if (req_data_ff.queue_index == QIDX_BITS'(q)) begin
                     length_in[q] = req_data_ff.queue_length;
                  end
               end
            end
            OP_SET_LAST: begin
               for (int q = 0; q < NUM_QUEUES; q++) begin
                  if (req_data_ff.queue_index == QIDX_BITS'(q)) begin
                     last_time_in[q] = new_stamp;
                  end
               end
            end
            OP_SET_WEIGHT: begin
               high_weight_in = req_data_ff.weight_update;
            end
         endcase
         rsp_data_in.reported_weight = (op_type'(req_data_ff.operation) == OP_SET_WEIGHT) ?
                                       req_data_ff.weight_update : high_weight_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         low_weight_ff  <= LOW_WEIGHT_RST;
         mid_weight_ff  <= MID_WEIGHT_RST;
         high_weight_ff <= HIGH_WEIGHT_RST;
         length_ff      <= '0;
         last_time_ff   <= '0;
      end else begin
         req_valid_ff   <= req_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         low_weight_ff  <= low_weight_in;
         mid_weight_ff  <= mid_weight_in;
         high_weight_ff <= high_weight_in;
         length_ff      <= length_in;
         last_time_ff   <= last_time_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
